// ===== design/hds_pkg.sv =====
// Shared types and constants for the heat diffusion stencil step unit.
// No dependencies; imported by every module of the block.
package hds_pkg;

  localparam int TEMP_WIDTH  = 16;             // signed Q(TEMP_WIDTH-8).8
  localparam int GAIN_WIDTH  = 16;             // unsigned Q4.12
  localparam int GAIN_FRAC   = 12;
  localparam int LAP_WIDTH   = TEMP_WIDTH + 2; // l - 2c + r, exact
  localparam int PROD_WIDTH  = LAP_WIDTH + GAIN_WIDTH + 1;
  localparam int QUO_WIDTH   = PROD_WIDTH - GAIN_FRAC;
  localparam int SUM_WIDTH   = QUO_WIDTH + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 4;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_LEFT_BOUNDARY  = 2'd0;
  localparam logic [1:0] REG_RIGHT_BOUNDARY = 2'd1;
  localparam logic [1:0] REG_DIFFUSION_GAIN = 2'd2;

  // reset values
  localparam logic [TEMP_WIDTH-1:0] LEFT_BOUNDARY_RESET  = TEMP_WIDTH'(25600);
  localparam logic [TEMP_WIDTH-1:0] RIGHT_BOUNDARY_RESET = TEMP_WIDTH'(6400);
  localparam logic [GAIN_WIDTH-1:0] DIFFUSION_GAIN_RESET = GAIN_WIDTH'(40960);

  typedef struct packed {
    logic signed [TEMP_WIDTH-1:0] cell_temp;
    logic                         last_cell;
  } cell_word_t;

  typedef struct packed {
    logic signed [TEMP_WIDTH-1:0] new_temp;
    logic                         last_of_run;
  } result_word_t;

  // One queued job: stencil over (t0,t1,t2), and over (t1,t2,t3) when two_res.
  typedef struct packed {
    logic signed [TEMP_WIDTH-1:0] t0;
    logic signed [TEMP_WIDTH-1:0] t1;
    logic signed [TEMP_WIDTH-1:0] t2;
    logic signed [TEMP_WIDTH-1:0] t3;
    logic                         two_res;
    logic                         last;
  } job_t;

endpackage

// ===== design/hds_front.sv =====
// Front end: accepts cell words, tracks the two-cell window, builds jobs.
// Depends on hds_pkg.
module hds_front import hds_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cell_valid,
  output logic                         cell_stall,
  input  cell_word_t                   cell_word,
  input  logic signed [TEMP_WIDTH-1:0] left_boundary,
  input  logic signed [TEMP_WIDTH-1:0] right_boundary,
  input  logic                         queue_full,
  output logic                         push,
  output job_t                         job
);

  logic                         seen;
  logic signed [TEMP_WIDTH-1:0] left_neighbour;
  logic signed [TEMP_WIDTH-1:0] centre_cell;
  logic                         accept;

  assign cell_stall = queue_full;
  assign accept     = cell_valid & ~queue_full;
  // a first cell that is not also last only fills the window
  assign push       = accept & (seen | cell_word.last_cell);

  always_comb begin
    if (!seen) begin
      job.t0 = left_boundary;
      job.t1 = cell_word.cell_temp;
      job.t2 = right_boundary;
    end else begin
      job.t0 = left_neighbour;
      job.t1 = centre_cell;
      job.t2 = cell_word.cell_temp;
    end
    job.t3      = right_boundary;
    job.two_res = seen & cell_word.last_cell;
    job.last    = cell_word.last_cell;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (accept) begin
      seen <= ~cell_word.last_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_neighbour <= seen ? centre_cell : left_boundary;
      centre_cell    <= cell_word.cell_temp;
    end
  end

endmodule

// ===== design/hds_queue.sv =====
// Short job queue between front and back end.
// Depends on hds_pkg.
module hds_queue import hds_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head
);

  job_t                  slots [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr;
  logic [QPTR_WIDTH-1:0] rd_ptr;
  logic [QCNT_WIDTH-1:0] count;
  logic                  do_pop;

  assign full       = (count == QCNT_WIDTH'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop & head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

endmodule

// ===== design/hds_back.sv =====
// Back end: expands jobs into stencil results; Laplacian, multiply, round/saturate.
// Depends on hds_pkg.
module hds_back import hds_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  job_t                  head,
  output logic                  pop,
  input  logic [GAIN_WIDTH-1:0] diffusion_gain,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_word_t          result
);

  localparam logic signed [SUM_WIDTH-1:0] SAT_MAX =
    SUM_WIDTH'((64'sd1 <<< (TEMP_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_WIDTH-1:0] SAT_MIN = -SAT_MAX - SUM_WIDTH'(1);
  localparam logic signed [PROD_WIDTH-1:0] ROUND_HALF =
    PROD_WIDTH'(1) <<< (GAIN_FRAC - 1);

  logic advance;
  logic take;
  logic phase;

  logic signed [TEMP_WIDTH-1:0] op_l, op_c, op_r;
  logic signed [LAP_WIDTH-1:0]  lap;
  logic                         op_last;

  logic                         s1_valid;
  logic signed [TEMP_WIDTH-1:0] s1_c;
  logic signed [LAP_WIDTH-1:0]  s1_lap;
  logic                         s1_last;

  logic                         s2_valid;
  logic signed [TEMP_WIDTH-1:0] s2_c;
  logic signed [PROD_WIDTH-1:0] s2_prod;
  logic                         s2_last;

  logic signed [PROD_WIDTH-1:0] rounded;
  logic signed [QUO_WIDTH-1:0]  quo;
  logic signed [SUM_WIDTH-1:0]  sum;
  logic signed [TEMP_WIDTH-1:0] sat;

  // pipeline moves whenever the output register is free or being taken
  assign advance = ~result_valid | ~result_stall;
  assign take    = advance & head_valid;
  assign pop     = take & (phase | ~head.two_res);

  always_comb begin
    if (phase) begin
      op_l = head.t1;
      op_c = head.t2;
      op_r = head.t3;
    end else begin
      op_l = head.t0;
      op_c = head.t1;
      op_r = head.t2;
    end
    op_last = head.last & (phase | ~head.two_res);
    lap = LAP_WIDTH'(op_l) - (LAP_WIDTH'(op_c) <<< 1) + LAP_WIDTH'(op_r);
  end

  always_comb begin
    rounded = s2_prod + ROUND_HALF;
    quo     = rounded[PROD_WIDTH-1:GAIN_FRAC];
    sum     = SUM_WIDTH'(quo) + SUM_WIDTH'(s2_c);
    if (sum > SAT_MAX) begin
      sat = SAT_MAX[TEMP_WIDTH-1:0];
    end else if (sum < SAT_MIN) begin
      sat = SAT_MIN[TEMP_WIDTH-1:0];
    end else begin
      sat = sum[TEMP_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= 1'b0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      if (take) phase <= head.two_res & ~phase;
      s1_valid     <= take;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_c               <= op_c;
      s1_lap             <= lap;
      s1_last            <= op_last;
      s2_c               <= s1_c;
      s2_prod            <= $signed({1'b0, diffusion_gain}) * s1_lap;
      s2_last            <= s1_last;
      result.new_temp    <= sat;
      result.last_of_run <= s2_last;
    end
  end

endmodule

// ===== design/heat_diffusion_stencil_step_unit.sv =====
// Heat diffusion stencil step unit: one explicit Euler step of 1-D heat flow.
// A completing cell word passes the job queue, stages s1 and s2, then the
// output register. One cell word per cycle unless cell_stall; the back end emits
// one result a cycle unless result_stall, a row-end job holding the queue head for both results.
// Reset (rst, synchronous): queue and pipeline empty, row restarts, registers
// return to left 100.0, right 25.0, gain 10.0. Depends on hds_pkg.
module heat_diffusion_stencil_step_unit import hds_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // cell words in
  input  logic                      cell_valid,
  output logic                      cell_stall,
  input  cell_word_t                cell_word,
  // result words out
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_word_t              result,
  // APB register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  logic signed [TEMP_WIDTH-1:0] left_boundary;
  logic signed [TEMP_WIDTH-1:0] right_boundary;
  logic        [GAIN_WIDTH-1:0] diffusion_gain;
  logic                         reg_write;
  logic [1:0]                   reg_index;

  logic queue_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head;

  // ---------------------------------------------------------------------------
  // Register file. Writes land in the access phase; unknown indexes drop.
  // Boundaries are sampled by the front end as cells arrive, the gain by the
  // back end at multiply time (the gain is to be changed only while the block is idle; the block does not enforce it).
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign reg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_boundary  <= LEFT_BOUNDARY_RESET;
      right_boundary <= RIGHT_BOUNDARY_RESET;
      diffusion_gain <= DIFFUSION_GAIN_RESET;
    end else if (reg_write) begin
      case (reg_index)
        REG_LEFT_BOUNDARY:  left_boundary  <= pwdata[TEMP_WIDTH-1:0];
        REG_RIGHT_BOUNDARY: right_boundary <= pwdata[TEMP_WIDTH-1:0];
        REG_DIFFUSION_GAIN: diffusion_gain <= pwdata[GAIN_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // reads: boundaries sign extended, gain zero extended
  always_comb begin
    case (reg_index)
      REG_LEFT_BOUNDARY:  prdata = APB_DATA_WIDTH'(left_boundary);
      REG_RIGHT_BOUNDARY: prdata = APB_DATA_WIDTH'(right_boundary);
      REG_DIFFUSION_GAIN: prdata = APB_DATA_WIDTH'(diffusion_gain);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front end: holds left neighbour and centre cell, turns each cell word into
  // zero or one queued job (a job may carry two stencils at row end).
  // ---------------------------------------------------------------------------
  hds_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cell_valid     (cell_valid),
    .cell_stall     (cell_stall),
    .cell_word      (cell_word),
    .left_boundary  (left_boundary),
    .right_boundary (right_boundary),
    .queue_full     (queue_full),
    .push           (push),
    .job            (push_job)
  );

  // Decoupling queue; absorbs the extra result at each row end and
  // downstream stalls, so the front keeps taking words until the queue fills.
  hds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end: Laplacian, gain multiply, round half up, add and saturate,
  // ending in the output register.
  hds_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .diffusion_gain (diffusion_gain),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result)
  );

endmodule
